// ----- rtl/mts_pkg.sv -----
// Melody tone sequencer package: field widths, input mode codes, state
// encoding and the divider status word.
// No dependencies.
package mts_pkg;

	localparam int MODE_W     = 2;
	localparam int NOTE_W     = 6;
	localparam int FREQ_W     = 12;
	localparam int DUR_W      = 10;
	localparam int TICK_W     = 11;
	localparam int RELOAD_W   = 16;
	localparam int LEVEL_W    = 3;
	localparam int LVL_CALC_W = 5;
	localparam int TONE_SCALE = 16;

	localparam logic [TICK_W-1:0]   TICK_MAX   = 11'd2047;
	localparam logic [RELOAD_W-1:0] RELOAD_MAX = 16'hFFFF;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_START = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_ENTER  = 8'b0000_0100,
		ST_SCALE  = 8'b0000_1000,
		ST_MULT   = 8'b0001_0000,
		ST_DSTART = 8'b0010_0000,
		ST_DWAIT  = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/melody_tone_sequencer.sv -----
// Melody tone sequencer top level: note table, item sequencer, reload
// arithmetic and output register. Depends on mts_pkg, mts_ram, mts_div.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------------
//  input   | in_valid / in_ready   | mode, entry_index, entry_freq, entry_duration
//  output  | out_valid / out_ready | tone_on, reload_write, reload_value, counter_clear, note_index
//  config  | cfg_we (no wait)      | cfg_data (level)
//
// One word at a time, from acceptance to output register load: load, stop and ignored
// tick go to done; a tick inside a note passes check, a start into a rest enter, a note
// change into a rest check and enter, a start into a tone enter, scale, mult, dstart,
// dwait, a note change into a tone check too, then done. A bit-serial divider makes one
// quotient bit per cycle over the clock constant width. in_ready is high only in the
// idle state; a full output register holds the finished word until it is taken. Reset
// clears control state; the note table holds nothing defined until loaded.
module melody_tone_sequencer #(
	parameter int NOTES    = 64,
	parameter int CLOCK_HZ = 50000000,
	parameter int PRESCALE = 128,
	parameter int FREQ_MOD = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mts_pkg::LEVEL_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mts_pkg::MODE_W-1:0]      mode,
	input  logic [mts_pkg::NOTE_W-1:0]      entry_index,
	input  logic [mts_pkg::FREQ_W-1:0]      entry_freq,
	input  logic [mts_pkg::DUR_W-1:0]       entry_duration,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            tone_on,
	output logic                            reload_write,
	output logic [mts_pkg::RELOAD_W-1:0]    reload_value,
	output logic                            counter_clear,
	output logic [mts_pkg::NOTE_W-1:0]      note_index
);
	import mts_pkg::*;

	localparam int IW    = (NOTES > 1) ? $clog2(NOTES) : 1;
	localparam int EW    = FREQ_W + DUR_W;
	localparam int SCALE = PRESCALE * TONE_SCALE;
	localparam int SW    = $clog2(SCALE + 1);
	localparam int VW    = $clog2(FREQ_MOD + 1);
	localparam int DENW  = FREQ_W + SW + VW;
	localparam int NW    = $clog2(CLOCK_HZ + 1);

	state_t               state_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [NOTE_W-1:0]    note_q;
	logic [TICK_W-1:0]    tick_q;
	logic                 tone_q;
	logic                 playing_q;
	logic                 wr_q;
	logic                 clr_q;
	logic [RELOAD_W-1:0]  val_q;
	logic [FREQ_W-1:0]    freq_q;
	logic [DENW-1:0]      prod_q;

	logic                 out_valid_q;
	logic                 out_tone_q;
	logic                 out_wr_q;
	logic [RELOAD_W-1:0]  out_val_q;
	logic                 out_clr_q;
	logic [NOTE_W-1:0]    out_note_q;

	logic                 accept;
	mode_t                mode_in;
	logic                 ram_we;
	logic [IW-1:0]        ram_raddr;
	logic [EW-1:0]        ram_rdata;
	logic [FREQ_W-1:0]    rd_freq;
	logic [DUR_W-1:0]     rd_dur;
	logic [NOTE_W-1:0]    note_nx;
	logic [LVL_CALC_W-1:0] lvl_ext;
	logic [LVL_CALC_W-1:0] lvl_clamp;
	logic [LVL_CALC_W-1:0] div_factor;
	logic                 div_start;
	div_stat_t            div_stat;
	logic [NW-1:0]        div_quo;
	logic                 out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign mode_in  = mode_t'(mode);
	assign out_free = !out_valid_q || out_ready;

	// next note position, wrapping past the last entry
	assign note_nx = (note_q == NOTE_W'(NOTES - 1)) ? '0 : note_q + NOTE_W'(1);

	// table write on load, ignoring positions beyond the table
	assign ram_we = accept && (mode_in == MODE_LOAD) &&
		({1'b0, entry_index} < (NOTE_W + 1)'(NOTES));

	// read address: the current note for a tick check, note zero for start,
	// the next note during the check, used once a change is decided
	always_comb begin
		ram_raddr = note_q[IW-1:0];
		if (state_q == ST_IDLE && mode_in == MODE_START) begin
			ram_raddr = '0;
		end else if (state_q == ST_CHECK) begin
			ram_raddr = note_nx[IW-1:0];
		end
	end

	mts_ram #(
		.WIDTH (EW),
		.DEPTH (NOTES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (entry_index[IW-1:0]),
		.wdata ({entry_freq, entry_duration}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_freq = ram_rdata[EW-1:DUR_W];
	assign rd_dur  = ram_rdata[DUR_W-1:0];

	// divisor factor FREQ_MOD - level, level clamped below FREQ_MOD
	always_comb begin
		lvl_ext    = LVL_CALC_W'(level_q);
		lvl_clamp  = (lvl_ext > LVL_CALC_W'(FREQ_MOD - 1)) ?
			LVL_CALC_W'(FREQ_MOD - 1) : lvl_ext;
		div_factor = LVL_CALC_W'(FREQ_MOD) - lvl_clamp;
	end

	assign div_start = (state_q == ST_DSTART);

	mts_div #(
		.NW (NW),
		.DW (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NW'(CLOCK_HZ)),
		.den    (prod_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cfg_we) begin
			level_q <= cfg_data;
		end
	end

	// sequencer and melody state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			note_q    <= '0;
			tick_q    <= '0;
			tone_q    <= 1'b0;
			playing_q <= 1'b0;
			wr_q      <= 1'b0;
			clr_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wr_q    <= 1'b0;
						clr_q   <= 1'b0;
						state_q <= ST_DONE;
						case (mode_in)
							MODE_START: begin
								tick_q    <= '0;
								playing_q <= 1'b1;
								note_q    <= '0;
								state_q   <= ST_ENTER;
							end
							MODE_STOP: begin
								playing_q <= 1'b0;
								tone_q    <= 1'b0;
							end
							MODE_TICK: begin
								if (playing_q) begin
									state_q <= ST_CHECK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHECK: begin
					// advance once the count has reached the note length
					if (tick_q >= {1'b0, rd_dur}) begin
						tick_q  <= TICK_W'(1);
						clr_q   <= 1'b1;
						note_q  <= note_nx;
						state_q <= ST_ENTER;
					end else begin
						if (tick_q < TICK_MAX) begin
							tick_q <= tick_q + TICK_W'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_ENTER: begin
					// rest: tone off, no reload; tone: tone on, compute reload
					if (rd_freq == '0) begin
						tone_q  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						tone_q  <= 1'b1;
						wr_q    <= 1'b1;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// reload datapath: frequency, scaled product, saturated quotient
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			val_q <= '0;
		end
		if (state_q == ST_ENTER) begin
			freq_q <= rd_freq;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= DENW'(freq_q) * DENW'(SCALE);
		end
		if (state_q == ST_MULT) begin
			prod_q <= DENW'(prod_q[FREQ_W+SW-1:0]) * DENW'(div_factor[VW-1:0]);
		end
		if (state_q == ST_DWAIT && div_stat.done) begin
			val_q <= (div_quo > NW'(RELOAD_MAX)) ? RELOAD_MAX : div_quo[RELOAD_W-1:0];
		end
	end

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_tone_q <= tone_q;
			out_wr_q   <= wr_q;
			out_val_q  <= val_q;
			out_clr_q  <= clr_q;
			out_note_q <= note_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign tone_on       = out_tone_q;
	assign reload_write  = out_wr_q;
	assign reload_value  = out_val_q;
	assign counter_clear = out_clr_q;
	assign note_index    = out_note_q;

endmodule

// ----- rtl/mts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mts_ram #(
	parameter int WIDTH = 22,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mts_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on mts_pkg for the status word.
module mts_div #(
	parameter int NW = 26,
	parameter int DW = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	output mts_pkg::div_stat_t  stat,
	output logic [NW-1:0]       quo
);
	import mts_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;
	logic          ge;

	// shift in the next dividend bit and trial-subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[NW-1]};
		diff   = rem_sh - {1'b0, den};
		ge     = (rem_sh >= {1'b0, den});
	end

	// control: iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	// datapath: remainder and quotient/dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule
